/* rtl/bpa_pkg.sv */
// Shared constants, codes, types and helpers for the bitmap page allocator.
// Used by bpa_summary and bitmap_page_allocator; depends on nothing else.
`timescale 1ns / 1ps

package bpa_pkg;

	// Geometry (WORD_BITS is a power of two)
	localparam int TOTAL_PAGES = 32768;
	localparam int PAGE_SHIFT  = 12;
	localparam int WORD_BITS   = 64;

	// Field widths
	localparam int ADDR_W     = 48;
	localparam int RES_W      = 15;
	localparam int CMD_W      = 2;
	localparam int STATUS_W   = 2;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 48;

	// Derived geometry
	localparam int WORD_SHIFT = $clog2(WORD_BITS);
	localparam int NWORDS     = (TOTAL_PAGES + WORD_BITS - 1) / WORD_BITS;
	localparam int WIDX_W     = (NWORDS > 1) ? $clog2(NWORDS) : 1;
	localparam int PIDX_W     = WIDX_W + WORD_SHIFT;
	localparam int PAD_BITS   = NWORDS * WORD_BITS - TOTAL_PAGES;
	localparam int EXT_W      = ((RES_W > PIDX_W) ? RES_W : PIDX_W) + 1;

	// Summary tree: groups of bitmap words
	localparam int GRP_SHIFT = 6;
	localparam int GRP_WORDS = 1 << GRP_SHIFT;
	localparam int NGROUPS   = (NWORDS + GRP_WORDS - 1) / GRP_WORDS;
	localparam int GSEL_W    = (NGROUPS > 1) ? $clog2(NGROUPS) : 1;

	// Commands
	localparam logic [CMD_W-1:0] CMD_ALLOC = 2'd0;
	localparam logic [CMD_W-1:0] CMD_FREE  = 2'd1;
	localparam logic [CMD_W-1:0] CMD_INIT  = 2'd2;
	localparam logic [CMD_W-1:0] CMD_NOP   = 2'd3;

	// Status codes
	localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] ST_OOM   = 2'd1;
	localparam logic [STATUS_W-1:0] ST_RANGE = 2'd2;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_MEM_BASE = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_RES_LAST = 1'd1;

	localparam logic [ADDR_W-1:0] MEM_BASE_RST = 48'h0000_4000_0000;

	typedef logic [WORD_BITS-1:0] word_t;
	typedef logic [WIDX_W-1:0]    widx_t;

	// Bits past the last page, kept set so they never look free
	localparam word_t PAD_MASK = ~({WORD_BITS{1'b1}} >> PAD_BITS);

	typedef struct packed {
		logic  en;
		widx_t idx;
		logic  notfull;
	} sum_upd_t;

	typedef struct packed {
		logic  found;
		widx_t word;
	} sum_pick_t;

	function automatic logic [WORD_SHIFT-1:0] lowest_one(input word_t v);
		logic [WORD_SHIFT-1:0] r;
		r = '0;
		for (int i = WORD_BITS - 1; i >= 0; i--) begin
			if (v[i]) r = WORD_SHIFT'(i);
		end
		return r;
	endfunction

endpackage

/* rtl/bpa_summary.sv */
// Non-full word summary with a registered two-level lowest-index search.
// Depends on bpa_pkg.
`timescale 1ns / 1ps

module bpa_summary (
	input  logic               clk,
	input  logic               arst_n,
	input  bpa_pkg::sum_upd_t  upd,
	output bpa_pkg::sum_pick_t pick
);

	localparam int PAD_W = bpa_pkg::NGROUPS * bpa_pkg::GRP_WORDS;

	logic [bpa_pkg::NWORDS-1:0] notfull_q;
	logic [PAD_W-1:0]           nf_pad;
	logic                       hit_s1 [bpa_pkg::NGROUPS];
	logic [bpa_pkg::GRP_SHIFT-1:0] idx_s1 [bpa_pkg::NGROUPS];
	logic [bpa_pkg::GSEL_W+bpa_pkg::GRP_SHIFT-1:0] word_full;

	function automatic logic [bpa_pkg::GRP_SHIFT-1:0] grp_lowest(
		input logic [bpa_pkg::GRP_WORDS-1:0] v
	);
		logic [bpa_pkg::GRP_SHIFT-1:0] r;
		r = '0;
		for (int i = bpa_pkg::GRP_WORDS - 1; i >= 0; i--) begin
			if (v[i]) r = bpa_pkg::GRP_SHIFT'(i);
		end
		return r;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			notfull_q <= '0;
		end else if (upd.en) begin
			notfull_q[upd.idx] <= upd.notfull;
		end
	end

	always_comb begin
		nf_pad = '0;
		nf_pad[bpa_pkg::NWORDS-1:0] = notfull_q;
	end

	// First level: lowest non-full word in each group
	always_ff @(posedge clk) begin
		for (int g = 0; g < bpa_pkg::NGROUPS; g++) begin
			hit_s1[g] <= |nf_pad[g*bpa_pkg::GRP_WORDS +: bpa_pkg::GRP_WORDS];
			idx_s1[g] <= grp_lowest(nf_pad[g*bpa_pkg::GRP_WORDS +: bpa_pkg::GRP_WORDS]);
		end
	end

	// Second level: lowest group with a hit
	always_comb begin
		pick.found = 1'b0;
		word_full  = '0;
		for (int g = bpa_pkg::NGROUPS - 1; g >= 0; g--) begin
			if (hit_s1[g]) begin
				pick.found = 1'b1;
				word_full  = {bpa_pkg::GSEL_W'(g), idx_s1[g]};
			end
		end
		pick.word = word_full[bpa_pkg::WIDX_W-1:0];
	end

endmodule

/* rtl/bitmap_page_allocator.sv */
// First-fit bitmap page allocator: bitmap memory, command sequencer, config.
// Depends on bpa_pkg and bpa_summary.
//
//   channel | signals                                 | direction
//   --------+-----------------------------------------+----------
//   input   | in_valid, in_stall, cmd, addr           | in
//   output  | out_valid, out_stall, page_addr, status | out
//   config  | cfg_we, cfg_index, cfg_wdata            | in
//
// Alloc steps: summary pick with bitmap read, write-back, result load, idle; free
// has a range check in place of the pick. Out-of-memory allocs and bad frees skip
// the write-back, no-ops go straight to the result load. Init sweeps the bitmap
// memory one word a cycle; after reset the same sweep clears the bitmap with
// in_stall high. A result waits in the output register while out_stall holds;
// the next command is taken meanwhile and held at its result load.
`timescale 1ns / 1ps

module bitmap_page_allocator (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic [bpa_pkg::CMD_W-1:0]         cmd,
	input  logic [bpa_pkg::ADDR_W-1:0]        addr,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [bpa_pkg::ADDR_W-1:0]        page_addr,
	output logic [bpa_pkg::STATUS_W-1:0]      status,
	input  logic                              cfg_we,
	input  logic [bpa_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [bpa_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

	typedef enum logic [2:0] {
		S_SWEEP,
		S_IDLE,
		S_PICK,
		S_FCHK,
		S_MOD,
		S_PUSH
	} state_t;

	localparam int FPAGE_W = bpa_pkg::ADDR_W - bpa_pkg::PAGE_SHIFT;

	state_t state_q;
	logic   init_q;
	bpa_pkg::widx_t sweep_q;

	logic [bpa_pkg::ADDR_W-1:0] mem_base_q;
	logic [bpa_pkg::RES_W-1:0]  res_last_q;

	// Bitmap memory
	bpa_pkg::word_t used_bitmap_q [bpa_pkg::NWORDS];
	bpa_pkg::word_t rd_data_q;
	logic           mem_we;
	bpa_pkg::widx_t mem_waddr;
	bpa_pkg::word_t mem_wdata;
	logic           rd_en;
	bpa_pkg::widx_t rd_addr;

	bpa_pkg::sum_upd_t  upd;
	bpa_pkg::sum_pick_t pick;

	// Datapath
	logic [bpa_pkg::CMD_W-1:0]      op_q;
	logic [bpa_pkg::ADDR_W-1:0]     addr_q;
	bpa_pkg::widx_t                 word_q;
	logic [bpa_pkg::WORD_SHIFT-1:0] bit_q;
	logic [bpa_pkg::ADDR_W-1:0]     res_addr_q;
	logic [bpa_pkg::STATUS_W-1:0]   res_status_q;

	logic                           accept;
	logic                           push_fire;
	logic                           res_ld;
	logic [bpa_pkg::ADDR_W-1:0]     res_addr_d;
	logic [bpa_pkg::STATUS_W-1:0]   res_status_d;

	logic [bpa_pkg::EXT_W-1:0]      last_ext;
	logic [bpa_pkg::EXT_W-1:0]      last_sat;
	bpa_pkg::widx_t                 last_word;
	logic [bpa_pkg::WORD_SHIFT-1:0] last_bit;
	bpa_pkg::word_t                 sweep_pat;

	logic [bpa_pkg::ADDR_W:0]       fdiff;
	logic [FPAGE_W-1:0]             fpage;
	logic                           f_ok;

	logic [bpa_pkg::WORD_SHIFT-1:0] abit;
	bpa_pkg::word_t                 anew;
	bpa_pkg::word_t                 fnew;
	logic [bpa_pkg::PIDX_W-1:0]     apage;
	logic [bpa_pkg::ADDR_W-1:0]     aaddr;

	bpa_summary u_summary (
		.clk    (clk),
		.arst_n (arst_n),
		.upd    (upd),
		.pick   (pick)
	);

	assign in_stall  = (state_q != S_IDLE);
	assign accept    = in_valid && !in_stall;
	assign push_fire = (state_q == S_PUSH) && (!out_valid || !out_stall);

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mem_base_q <= bpa_pkg::MEM_BASE_RST;
			res_last_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				bpa_pkg::CFG_MEM_BASE: mem_base_q <= cfg_wdata[bpa_pkg::ADDR_W-1:0];
				bpa_pkg::CFG_RES_LAST: res_last_q <= cfg_wdata[bpa_pkg::RES_W-1:0];
				default: ;
			endcase
		end
	end

	// Sweep pattern: init marks pages up to the reserved one, reset clears
	always_comb begin
		last_ext  = bpa_pkg::EXT_W'(res_last_q);
		last_sat  = (last_ext > bpa_pkg::EXT_W'(bpa_pkg::TOTAL_PAGES - 1)) ?
			bpa_pkg::EXT_W'(bpa_pkg::TOTAL_PAGES - 1) : last_ext;
		last_word = last_sat[bpa_pkg::WORD_SHIFT +: bpa_pkg::WIDX_W];
		last_bit  = last_sat[bpa_pkg::WORD_SHIFT-1:0];
		if (!init_q) begin
			sweep_pat = '0;
		end else if (sweep_q < last_word) begin
			sweep_pat = '1;
		end else if (sweep_q == last_word) begin
			sweep_pat = {bpa_pkg::WORD_BITS{1'b1}} >> (~last_bit);
		end else begin
			sweep_pat = '0;
		end
		if (sweep_q == bpa_pkg::WIDX_W'(bpa_pkg::NWORDS - 1)) begin
			sweep_pat = sweep_pat | bpa_pkg::PAD_MASK;
		end
	end

	// Free range check
	always_comb begin
		fdiff = {1'b0, addr_q} - {1'b0, mem_base_q};
		fpage = fdiff[bpa_pkg::ADDR_W-1:bpa_pkg::PAGE_SHIFT];
		f_ok  = !fdiff[bpa_pkg::ADDR_W] && (fpage < FPAGE_W'(bpa_pkg::TOTAL_PAGES));
	end

	// Word modify
	always_comb begin
		abit  = bpa_pkg::lowest_one(~rd_data_q);
		anew  = rd_data_q | (bpa_pkg::word_t'(1) << abit);
		fnew  = rd_data_q & ~(bpa_pkg::word_t'(1) << bit_q);
		apage = {word_q, abit};
		aaddr = mem_base_q + (bpa_pkg::ADDR_W'(apage) << bpa_pkg::PAGE_SHIFT);
	end

	// Memory and summary access
	always_comb begin
		mem_we      = 1'b0;
		mem_waddr   = sweep_q;
		mem_wdata   = sweep_pat;
		rd_en       = 1'b0;
		rd_addr     = pick.word;
		upd.en      = 1'b0;
		upd.idx     = sweep_q;
		upd.notfull = ~&sweep_pat;
		case (state_q)
			S_SWEEP: begin
				mem_we = 1'b1;
				upd.en = 1'b1;
			end
			S_PICK: begin
				rd_en   = pick.found;
				rd_addr = pick.word;
			end
			S_FCHK: begin
				rd_en   = f_ok;
				rd_addr = fpage[bpa_pkg::WORD_SHIFT +: bpa_pkg::WIDX_W];
			end
			S_MOD: begin
				mem_we    = 1'b1;
				mem_waddr = word_q;
				upd.en    = 1'b1;
				upd.idx   = word_q;
				if (op_q == bpa_pkg::CMD_ALLOC) begin
					mem_wdata   = anew;
					upd.notfull = ~&anew;
				end else begin
					mem_wdata   = fnew;
					upd.notfull = 1'b1;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) used_bitmap_q[mem_waddr] <= mem_wdata;
		if (rd_en) rd_data_q <= used_bitmap_q[rd_addr];
	end

	// Result selection
	always_comb begin
		res_ld       = 1'b0;
		res_addr_d   = '0;
		res_status_d = bpa_pkg::ST_OK;
		case (state_q)
			S_IDLE: res_ld = accept && (cmd == bpa_pkg::CMD_NOP);
			S_SWEEP: res_ld = init_q;
			S_PICK: begin
				res_ld       = !pick.found;
				res_status_d = bpa_pkg::ST_OOM;
			end
			S_FCHK: begin
				res_ld       = !f_ok;
				res_status_d = bpa_pkg::ST_RANGE;
			end
			S_MOD: begin
				res_ld     = 1'b1;
				res_addr_d = (op_q == bpa_pkg::CMD_ALLOC) ? aaddr : '0;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q   <= cmd;
			addr_q <= addr;
		end
		if (state_q == S_PICK) word_q <= pick.word;
		if (state_q == S_FCHK) begin
			word_q <= fpage[bpa_pkg::WORD_SHIFT +: bpa_pkg::WIDX_W];
			bit_q  <= fpage[bpa_pkg::WORD_SHIFT-1:0];
		end
		if (res_ld) begin
			res_addr_q   <= res_addr_d;
			res_status_q <= res_status_d;
		end
		if (push_fire) begin
			page_addr <= res_addr_q;
			status    <= res_status_q;
		end
	end

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_SWEEP;
			init_q    <= 1'b0;
			sweep_q   <= '0;
			out_valid <= 1'b0;
		end else begin
			if (push_fire) begin
				out_valid <= 1'b1;
			end else if (!out_stall) begin
				out_valid <= 1'b0;
			end
			case (state_q)
				S_SWEEP: begin
					if (sweep_q == bpa_pkg::WIDX_W'(bpa_pkg::NWORDS - 1)) begin
						sweep_q <= '0;
						state_q <= init_q ? S_PUSH : S_IDLE;
					end else begin
						sweep_q <= sweep_q + 1'b1;
					end
				end
				S_IDLE: begin
					if (accept) begin
						case (cmd)
							bpa_pkg::CMD_ALLOC: state_q <= S_PICK;
							bpa_pkg::CMD_FREE:  state_q <= S_FCHK;
							bpa_pkg::CMD_INIT: begin
								init_q  <= 1'b1;
								sweep_q <= '0;
								state_q <= S_SWEEP;
							end
							default: state_q <= S_PUSH;
						endcase
					end
				end
				S_PICK: state_q <= pick.found ? S_MOD : S_PUSH;
				S_FCHK: state_q <= f_ok ? S_MOD : S_PUSH;
				S_MOD:  state_q <= S_PUSH;
				S_PUSH: begin
					if (push_fire) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

`ifndef SYNTHESIS
	a_no_rw_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(mem_we && rd_en))
		else $error("bitmap read and write in the same cycle");

	a_alloc_word_has_room: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_MOD && op_q == bpa_pkg::CMD_ALLOC) |-> !(&rd_data_q))
		else $error("summary picked a full bitmap word");

	a_busy_after_transfer: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> in_stall)
		else $error("input taken again before the command finished");

	a_result_from_push: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(state_q == S_PUSH))
		else $error("result presented outside the result load");
`endif

endmodule

/* test/bitmap_page_allocator_tb.sv */
// Self-checking testbench for bitmap_page_allocator: directed and random command
// streams, a first-fit bitmap predictor and a result scoreboard.
// Depends on bpa_pkg and the bitmap_page_allocator RTL.
`timescale 1ns / 1ps

module bitmap_page_allocator_tb;

	localparam int STALL_LIMIT = 5000;
	localparam int HOLD_CYCLES = 300;
	localparam logic [bpa_pkg::ADDR_W-1:0] ADDR_ONES = '1;
	localparam logic [bpa_pkg::ADDR_W-1:0] TOP_PAGE_BASE = 48'hFFFF_FFFF_F000;

	typedef struct packed {
		logic [bpa_pkg::CMD_W-1:0]  op;
		logic [bpa_pkg::ADDR_W-1:0] address;
	} page_cmd_t;

	typedef struct packed {
		logic [bpa_pkg::ADDR_W-1:0]   page_addr;
		logic [bpa_pkg::STATUS_W-1:0] status;
	} page_result_t;

	logic                           clk = 1'b0;
	logic                           arst_n = 1'b0;
	logic                           in_valid = 1'b0;
	logic                           in_stall;
	logic [bpa_pkg::CMD_W-1:0]      cmd = bpa_pkg::CMD_NOP;
	logic [bpa_pkg::ADDR_W-1:0]     addr = '0;
	logic                           out_valid;
	logic                           out_stall = 1'b0;
	logic [bpa_pkg::ADDR_W-1:0]     page_addr;
	logic [bpa_pkg::STATUS_W-1:0]   status;
	logic                           cfg_we = 1'b0;
	logic [bpa_pkg::CFG_IDX_W-1:0]  cfg_index = bpa_pkg::CFG_MEM_BASE;
	logic [bpa_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;

	page_cmd_t    cmd_q[$];
	page_result_t page_result_q[$];
	page_cmd_t    drv_cmd;
	page_result_t got_result;
	logic         in_taken = 1'b0;
	int           send_idle_pct = 0;
	int           recv_stall_pct = 0;
	int           hold_token = 0;
	int           hold_seen = 0;
	int           hold_left = 0;
	int           idle_cycles = 0;
	int           mismatch_cnt = 0;

	// Predictor state
	logic [bpa_pkg::WORD_BITS-1:0] bitmap_words [bpa_pkg::NWORDS];
	logic [bpa_pkg::ADDR_W-1:0]    base_addr_r;
	logic [bpa_pkg::RES_W-1:0]     reserved_last_r;

	bitmap_page_allocator DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.cmd       (cmd),
		.addr      (addr),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.page_addr (page_addr),
		.status    (status),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	function automatic page_result_t predict_page_op(input logic [bpa_pkg::CMD_W-1:0] op,
			input logic [bpa_pkg::ADDR_W-1:0] address);
		page_result_t r;
		logic [bpa_pkg::ADDR_W-1:0] pg;
		int unsigned last;
		logic found;
		r.page_addr = '0;
		r.status = bpa_pkg::ST_OK;
		found = 1'b0;
		case (op)
		bpa_pkg::CMD_ALLOC: begin
			r.status = bpa_pkg::ST_OOM;
			for (int w = 0; w < bpa_pkg::NWORDS && !found; w++) begin
				if (bitmap_words[w] != '1) begin
					for (int b = 0; b < bpa_pkg::WORD_BITS && !found; b++) begin
						if (!bitmap_words[w][b]) begin
							found = 1'b1;
							bitmap_words[w][b] = 1'b1;
							r.page_addr = base_addr_r
								+ (bpa_pkg::ADDR_W'(w * bpa_pkg::WORD_BITS + b)
								<< bpa_pkg::PAGE_SHIFT);
							r.status = bpa_pkg::ST_OK;
						end
					end
				end
			end
		end
		bpa_pkg::CMD_FREE: begin
			if (address < base_addr_r) begin
				r.status = bpa_pkg::ST_RANGE;
			end else begin
				pg = (address - base_addr_r) >> bpa_pkg::PAGE_SHIFT;
				if (pg >= bpa_pkg::TOTAL_PAGES)
					r.status = bpa_pkg::ST_RANGE;
				else
					bitmap_words[pg >> bpa_pkg::WORD_SHIFT][pg[bpa_pkg::WORD_SHIFT-1:0]]
						= 1'b0;
			end
		end
		bpa_pkg::CMD_INIT: begin
			last = reserved_last_r;
			if (last > bpa_pkg::TOTAL_PAGES - 1)
				last = bpa_pkg::TOTAL_PAGES - 1;
			for (int w = 0; w < bpa_pkg::NWORDS; w++) begin
				for (int b = 0; b < bpa_pkg::WORD_BITS; b++)
					bitmap_words[w][b] = (w * bpa_pkg::WORD_BITS + b <= last);
			end
		end
		default: ;
		endcase
		return r;
	endfunction

	// Sender: present the next pending command once the current one is transferred
	always @(negedge clk) begin
		if (arst_n && (!in_valid || in_taken)) begin
			if (cmd_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
				drv_cmd = cmd_q.pop_front();
				in_valid <= 1'b1;
				cmd <= drv_cmd.op;
				addr <= drv_cmd.address;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Receiver: long hold-off on request, random stall otherwise
	always @(negedge clk) begin
		if (hold_seen != hold_token) begin
			hold_seen <= hold_token;
			hold_left <= HOLD_CYCLES;
			out_stall <= 1'b1;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(99) < recv_stall_pct);
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			foreach (bitmap_words[w])
				bitmap_words[w] = '0;
			base_addr_r = bpa_pkg::MEM_BASE_RST;
			reserved_last_r = '0;
			in_taken <= 1'b0;
		end else begin
			in_taken <= in_valid && !in_stall;
			if (cfg_we) begin
				if (cfg_index == bpa_pkg::CFG_MEM_BASE)
					base_addr_r = cfg_wdata[bpa_pkg::ADDR_W-1:0];
				else if (cfg_index == bpa_pkg::CFG_RES_LAST)
					reserved_last_r = cfg_wdata[bpa_pkg::RES_W-1:0];
			end
			if (out_valid && !out_stall) begin
				if (page_result_q.size() == 0) begin
					$display("%0t: unexpected result: expected none, actual %h status %0d",
						$time, page_addr, status);
					mismatch_cnt++;
				end else begin
					got_result = page_result_q.pop_front();
					if (page_addr !== got_result.page_addr) begin
						$display("%0t: page_addr mismatch: expected %h, actual %h",
							$time, got_result.page_addr, page_addr);
						mismatch_cnt++;
					end
					if (status !== got_result.status) begin
						$display("%0t: status mismatch: expected %0d, actual %0d",
							$time, got_result.status, status);
						mismatch_cnt++;
					end
				end
			end
			if (in_valid && !in_stall)
				page_result_q.push_back(predict_page_op(cmd, addr));
		end
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("%0t: no transfer for %0d cycles", $time, idle_cycles);
			$display("RESULT: ERROR");
			$finish;
		end
	end

	task automatic queue_cmd(input logic [bpa_pkg::CMD_W-1:0] op,
			input logic [bpa_pkg::ADDR_W-1:0] address);
		cmd_q.push_back('{op: op, address: address});
	endtask

	function automatic logic [bpa_pkg::ADDR_W-1:0] page_start(
			input logic [bpa_pkg::ADDR_W-1:0] base, input int unsigned pg);
		return base + (bpa_pkg::ADDR_W'(pg) << bpa_pkg::PAGE_SHIFT);
	endfunction

	function automatic logic [bpa_pkg::ADDR_W-1:0] rand_addr();
		return bpa_pkg::ADDR_W'({$urandom, $urandom});
	endfunction

	task automatic write_cfg(input logic [bpa_pkg::CFG_IDX_W-1:0] idx,
			input logic [bpa_pkg::CFG_DATA_W-1:0] data);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= data;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic drain();
		while (cmd_q.size() != 0 || in_valid || page_result_q.size() != 0)
			@(posedge clk);
	endtask

	task automatic random_phase(input int send_pct, input int stall_pct,
			input logic [bpa_pkg::ADDR_W-1:0] base, input logic [bpa_pkg::RES_W-1:0] res,
			input bit junk_hi, input int n, input bit hold);
		logic [bpa_pkg::CFG_DATA_W-1:0] res_word;
		int unsigned sel;
		int unsigned pg;
		res_word = junk_hi ? bpa_pkg::CFG_DATA_W'({$urandom, $urandom}) : '0;
		res_word[bpa_pkg::RES_W-1:0] = res;
		write_cfg(bpa_pkg::CFG_MEM_BASE, base);
		write_cfg(bpa_pkg::CFG_RES_LAST, res_word);
		send_idle_pct = send_pct;
		recv_stall_pct = stall_pct;
		if (hold)
			hold_token++;
		queue_cmd(bpa_pkg::CMD_INIT, rand_addr());
		repeat (n) begin
			sel = $urandom_range(99);
			if (sel < 45) begin
				queue_cmd(bpa_pkg::CMD_ALLOC, rand_addr());
			end else if (sel < 75) begin
				pg = res + 1 + $urandom_range(47);
				queue_cmd(bpa_pkg::CMD_FREE, page_start(base, pg)
					+ ($urandom_range(1) ? $urandom_range(4095) : 0));
			end else if (sel < 82) begin
				queue_cmd(bpa_pkg::CMD_INIT, rand_addr());
			end else if (sel < 86) begin
				queue_cmd(bpa_pkg::CMD_NOP, rand_addr());
			end else if (sel < 93) begin
				queue_cmd(bpa_pkg::CMD_FREE, rand_addr());
			end else if ($urandom_range(1)) begin
				queue_cmd(bpa_pkg::CMD_FREE, base - 1 - $urandom_range(8191));
			end else begin
				queue_cmd(bpa_pkg::CMD_FREE,
					page_start(base, bpa_pkg::TOTAL_PAGES + $urandom_range(99)));
			end
		end
		drain();
	endtask

	initial begin
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Reset values, bitmap still clear before the first init
		queue_cmd(bpa_pkg::CMD_ALLOC, '0);
		queue_cmd(bpa_pkg::CMD_ALLOC, ADDR_ONES);
		queue_cmd(bpa_pkg::CMD_FREE, bpa_pkg::MEM_BASE_RST + 48'h1FFF);
		queue_cmd(bpa_pkg::CMD_FREE, bpa_pkg::MEM_BASE_RST + 48'h1000);
		queue_cmd(bpa_pkg::CMD_ALLOC, '0);
		queue_cmd(bpa_pkg::CMD_FREE, '0);
		queue_cmd(bpa_pkg::CMD_FREE, bpa_pkg::MEM_BASE_RST - 1);
		queue_cmd(bpa_pkg::CMD_FREE,
			page_start(bpa_pkg::MEM_BASE_RST, bpa_pkg::TOTAL_PAGES));
		queue_cmd(bpa_pkg::CMD_FREE,
			page_start(bpa_pkg::MEM_BASE_RST, bpa_pkg::TOTAL_PAGES - 1));
		queue_cmd(bpa_pkg::CMD_FREE, ADDR_ONES);
		queue_cmd(bpa_pkg::CMD_NOP, ADDR_ONES);
		queue_cmd(bpa_pkg::CMD_INIT, '0);
		queue_cmd(bpa_pkg::CMD_ALLOC, '0);
		drain();

		// Top of the address space, every page reserved
		write_cfg(bpa_pkg::CFG_MEM_BASE, TOP_PAGE_BASE);
		write_cfg(bpa_pkg::CFG_RES_LAST, bpa_pkg::CFG_DATA_W'(bpa_pkg::TOTAL_PAGES - 1));
		queue_cmd(bpa_pkg::CMD_INIT, '0);
		queue_cmd(bpa_pkg::CMD_ALLOC, '0);
		queue_cmd(bpa_pkg::CMD_FREE, TOP_PAGE_BASE + 48'hABC);
		queue_cmd(bpa_pkg::CMD_ALLOC, '0);
		queue_cmd(bpa_pkg::CMD_ALLOC, '0);
		queue_cmd(bpa_pkg::CMD_FREE, '0);
		drain();

		// Allocated address wraps past the top
		write_cfg(bpa_pkg::CFG_RES_LAST, '0);
		queue_cmd(bpa_pkg::CMD_INIT, '0);
		queue_cmd(bpa_pkg::CMD_ALLOC, '0);
		queue_cmd(bpa_pkg::CMD_ALLOC, '0);
		drain();

		write_cfg(bpa_pkg::CFG_MEM_BASE, '0);
		queue_cmd(bpa_pkg::CMD_FREE, 48'h1FFF);
		queue_cmd(bpa_pkg::CMD_ALLOC, '0);
		queue_cmd(bpa_pkg::CMD_FREE, ADDR_ONES);
		drain();

		random_phase(0, 0, '0, bpa_pkg::RES_W'($urandom_range(100)), 1'b0, 125, 1'b1);
		random_phase(51, 0,
			bpa_pkg::ADDR_W'({rand_addr() >> bpa_pkg::PAGE_SHIFT,
				{bpa_pkg::PAGE_SHIFT{1'b0}}}),
			bpa_pkg::RES_W'($urandom_range(300)), 1'b0, 125, 1'b0);
		random_phase(0, 51, bpa_pkg::ADDR_W'({$urandom_range(255), $urandom, 12'h000}),
			bpa_pkg::RES_W'(bpa_pkg::TOTAL_PAGES - 1 - $urandom_range(40)),
			1'b0, 125, 1'b0);
		random_phase(6, 6, rand_addr(),
			bpa_pkg::RES_W'($urandom_range(bpa_pkg::TOTAL_PAGES - 1)), 1'b1, 125, 1'b0);
		random_phase(0, 0, 48'hFFFF_FFF0_0000, bpa_pkg::RES_W'($urandom_range(300)),
			1'b0, 125, 1'b0);
		random_phase(0, 51, bpa_pkg::MEM_BASE_RST, '0, 1'b1, 125, 1'b0);

		repeat (20) @(posedge clk);
		if (mismatch_cnt == 0 && page_result_q.size() == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
